// File: rtl/cfq_pkg.sv
// ----------------------------------------------------------------------------
// cfq_pkg
// shared codes, widths and control/status bundles of the ring-buffer queue
// ----------------------------------------------------------------------------
package cfq_pkg;

	localparam int CFQ_DEPTH       = 32;
	localparam int CFQ_MAX_RESULTS = 32;
	localparam int DATA_W          = 32;
	localparam int CMD_W           = 2;
	localparam int STATUS_W        = 2;
	localparam int POS_W           = 5;

	localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TRV = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic accept;
		logic enq;
		logic deq_rd;
		logic deq_out;
		logic trv_rd;
		logic trv_out;
	} ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic trv_final;
	} sts_t;

endpackage

// File: rtl/cfq_ctrl.sv
// ----------------------------------------------------------------------------
// cfq_ctrl
// command sequencer: decodes an accepted item and steps the datapath
// ----------------------------------------------------------------------------
module cfq_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [cfq_pkg::CMD_W-1:0] command,
	input  cfq_pkg::sts_t           sts,
	output cfq_pkg::ctl_t           ctl,
	output logic                    busy
);
	import cfq_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_ENQ     = 6'b000010,
		S_DEQ_RD  = 6'b000100,
		S_DEQ_OUT = 6'b001000,
		S_TRV_RD  = 6'b010000,
		S_TRV_OUT = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (command)
						CMD_ENQ: state_d = S_ENQ;
						CMD_DEQ: state_d = S_DEQ_RD;
						CMD_TRV: state_d = S_TRV_RD;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_ENQ:     state_d = S_IDLE;
			S_DEQ_RD:  state_d = sts.empty ? S_IDLE : S_DEQ_OUT;
			S_DEQ_OUT: state_d = S_IDLE;
			S_TRV_RD:  state_d = sts.empty ? S_IDLE : S_TRV_OUT;
			S_TRV_OUT: state_d = sts.trv_final ? S_IDLE : S_TRV_RD;
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		ctl.accept  = accept;
		ctl.enq     = (state_q == S_ENQ);
		ctl.deq_rd  = (state_q == S_DEQ_RD);
		ctl.deq_out = (state_q == S_DEQ_OUT);
		ctl.trv_rd  = (state_q == S_TRV_RD);
		ctl.trv_out = (state_q == S_TRV_OUT);
	end

endmodule

// File: rtl/cfq_dpath.sv
// ----------------------------------------------------------------------------
// cfq_dpath
// entry memory, head/tail/count pointers, traverse walker and result register
// ----------------------------------------------------------------------------
module cfq_dpath #(
	parameter int DEPTH       = cfq_pkg::CFQ_DEPTH,
	parameter int MAX_RESULTS = cfq_pkg::CFQ_MAX_RESULTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cfq_pkg::ctl_t                     ctl,
	input  logic signed [cfq_pkg::DATA_W-1:0] value,
	output cfq_pkg::sts_t                     sts,
	output logic                              strobe,
	output logic [cfq_pkg::STATUS_W-1:0]      status,
	output logic signed [cfq_pkg::DATA_W-1:0] data,
	output logic [cfq_pkg::POS_W-1:0]         position,
	output logic                              last
);
	import cfq_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int LIM_W = (CNT_W > POS_W + 1) ? CNT_W : POS_W + 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [LIM_W-1:0] LIM_MAX  = LIM_W'(MAX_RESULTS);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] value_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [PTR_W-1:0]  walk_q;
	logic [CNT_W-1:0]  count_q;
	logic [POS_W-1:0]  pos_q;

	logic [PTR_W-1:0]  tail_next;
	logic [PTR_W-1:0]  head_next;
	logic [PTR_W-1:0]  walk_next;
	logic [PTR_W-1:0]  rd_addr;
	logic [LIM_W-1:0]  count_ext;
	logic [LIM_W-1:0]  lim;
	logic [LIM_W-1:0]  pos_inc;
	logic              enq_ok;
	logic              emit;

	logic                    strobe_q;
	logic [STATUS_W-1:0]     status_q;
	logic [DATA_W-1:0]       data_q;
	logic [POS_W-1:0]        position_q;
	logic                    last_q;

	assign tail_next = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
	assign head_next = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
	assign walk_next = (walk_q == PTR_LAST) ? '0 : walk_q + 1'b1;

	assign sts.empty = (count_q == '0);
	assign sts.full  = (count_q == CNT_W'(DEPTH));

	assign count_ext     = LIM_W'(count_q);
	assign lim           = (count_ext > LIM_MAX) ? LIM_MAX : count_ext;
	assign pos_inc       = LIM_W'(pos_q) + 1'b1;
	assign sts.trv_final = (pos_inc == lim);

	assign enq_ok  = ctl.enq && !sts.full;
	assign rd_addr = ctl.deq_rd ? head_q : walk_q;

	// entry memory
	always_ff @(posedge clk) begin
		if (enq_ok) begin
			mem_q[tail_next] <= value_q;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			value_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= PTR_LAST;
			count_q <= '0;
			walk_q  <= '0;
			pos_q   <= '0;
		end else begin
			if (ctl.accept) begin
				walk_q <= head_q;
				pos_q  <= '0;
			end else if (ctl.trv_out) begin
				walk_q <= walk_next;
				pos_q  <= pos_q + 1'b1;
			end
			if (enq_ok) begin
				tail_q  <= tail_next;
				count_q <= count_q + 1'b1;
			end else if (ctl.deq_out) begin
				head_q  <= head_next;
				count_q <= count_q - 1'b1;
			end
		end
	end

	// result register
	assign emit = ctl.enq || ctl.deq_out || ctl.trv_out ||
		((ctl.deq_rd || ctl.trv_rd) && sts.empty);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (ctl.enq) begin
				status_q   <= sts.full ? STAT_FULL : STAT_OK;
				data_q     <= '0;
				position_q <= '0;
				last_q     <= 1'b1;
			end else if (ctl.deq_rd) begin
				status_q   <= STAT_EMPTY;
				data_q     <= '1;
				position_q <= '0;
				last_q     <= 1'b1;
			end else if (ctl.trv_rd) begin
				status_q   <= STAT_EMPTY;
				data_q     <= '0;
				position_q <= '0;
				last_q     <= 1'b1;
			end else if (ctl.deq_out) begin
				status_q   <= STAT_OK;
				data_q     <= rd_q;
				position_q <= '0;
				last_q     <= 1'b1;
			end else begin
				status_q   <= STAT_OK;
				data_q     <= rd_q;
				position_q <= pos_q;
				last_q     <= sts.trv_final;
			end
		end
	end

	assign strobe   = strobe_q;
	assign status   = status_q;
	assign data     = signed'(data_q);
	assign position = position_q;
	assign last     = last_q;

endmodule

// File: rtl/circular_fifo_queue_top.sv
// ----------------------------------------------------------------------------
// circular_fifo_queue_top
// ring-buffer queue of signed words with enqueue, dequeue and traverse
//
//   channel   handshake       fields
//   input     start / busy    command, value
//   result    strobe          status, data, position, last
//
// an item is taken when start is high and busy is low
// enqueue has one step, dequeue a read and an output step, traverse a read
// and an output step per entry (at most 32); an empty queue ends at the read
// each result sits on the ports for one cycle with strobe high; the
// receiver cannot stall, and the next item may be taken while it shows
// reset clears head, count and the sequencer; the tail goes to the last slot
// ----------------------------------------------------------------------------
module circular_fifo_queue_top #(
	parameter int DEPTH = cfq_pkg::CFQ_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [cfq_pkg::CMD_W-1:0]         command,
	input  logic signed [cfq_pkg::DATA_W-1:0] value,
	output logic                              strobe,
	output logic [cfq_pkg::STATUS_W-1:0]      status,
	output logic signed [cfq_pkg::DATA_W-1:0] data,
	output logic [cfq_pkg::POS_W-1:0]         position,
	output logic                              last
);
	import cfq_pkg::*;

	ctl_t ctl;
	sts_t sts;

	cfq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.sts     (sts),
		.ctl     (ctl),
		.busy    (busy)
	);

	cfq_dpath #(
		.DEPTH       (DEPTH),
		.MAX_RESULTS (CFQ_MAX_RESULTS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.value    (value),
		.sts      (sts),
		.strobe   (strobe),
		.status   (status),
		.data     (data),
		.position (position),
		.last     (last)
	);

endmodule
